// ===== hdl/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared widths, constants and the month table for the Gregorian day
// distance pipeline.
// ----------------------------------------------------------------------------
package gdd_pkg;

    // field widths
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DIST_W  = 22;

    // internal widths
    localparam int unsigned DOY_W    = 9;   // day of year, up to 397
    localparam int unsigned SERIAL_W = 23;  // serial day number of one date

    // calendar constants
    localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
    localparam logic [MONTH_W-1:0] MONTH_MARCH   = 4'd3;

    // divide by 25 through a reciprocal multiply: q = (x * DIV25_MUL) >> DIV25_SHIFT
    // exact for every x below 2^14
    localparam int unsigned        DIV25_SHIFT = 17;
    localparam logic [12:0]        DIV25_MUL   = 13'd5243;
    localparam logic [4:0]         DIV25_BASE  = 5'd25;

    // saturation limit of the result field
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // days in the months before month m of a common year
    function automatic logic [DOY_W-1:0] months_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] days;
        case (m)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd365;
        endcase
        return days;
    endfunction

endpackage

// ===== hdl/gdd_ifs.sv =====
// ----------------------------------------------------------------------------
// gdd_ifs
// Valid/ready channels of the day distance block: the date pair request
// channel and the distance result channel.
// ----------------------------------------------------------------------------
interface gdd_dates_if
    import gdd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;

    modport source (
        output valid, first_year, first_month, first_day,
               second_year, second_month, second_day,
        input  ready
    );

    modport sink (
        input  valid, first_year, first_month, first_day,
               second_year, second_month, second_day,
        output ready
    );
endinterface

interface gdd_dist_if
    import gdd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] day_distance;

    modport source (
        output valid, day_distance,
        input  ready
    );

    modport sink (
        input  valid, day_distance,
        output ready
    );
endinterface

// ===== hdl/gregorian_date_difference.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_difference
// Absolute number of days between two proleptic Gregorian dates.
// Pipeline: five register stages, s1 to s5, with the result taken from s5.
// Throughput: one request per cycle while the result channel is not stalled;
// each stage has its own valid bit, so a bubble is filled even while the
// output is stalled.
// Reset: rst_n clears all stage valid bits; the payload is not reset.
// ----------------------------------------------------------------------------
module gregorian_date_difference
    import gdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gdd_dates_if.sink   dates,
    gdd_dist_if.source  result
);

    localparam int unsigned LANES = 2;

    // lane view of the request
    logic [YEAR_W-1:0]  in_year  [LANES];
    logic [MONTH_W-1:0] in_month [LANES];
    logic [DAY_W-1:0]   in_day   [LANES];

    assign in_year[0]  = dates.first_year;
    assign in_month[0] = dates.first_month;
    assign in_day[0]   = dates.first_day;
    assign in_year[1]  = dates.second_year;
    assign in_month[1] = dates.second_month;
    assign in_day[1]   = dates.second_day;

    // stage valid bits and per-stage ready
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic v1_next, v2_next, v3_next, v4_next, v5_next;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || result.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign dates.ready = rdy1;

    // stage 1: constant products and day-of-year base
    logic [YEAR_W-1:0]   s1_year_reg    [LANES];
    logic [SERIAL_W-1:0] s1_y365_reg    [LANES];
    logic [12:0]         s1_q4_reg      [LANES];
    logic [25:0]         s1_p100_reg    [LANES];
    logic [23:0]         s1_p400_reg    [LANES];
    logic [26:0]         s1_p25_reg     [LANES];
    logic [DOY_W-1:0]    s1_doy_reg     [LANES];
    logic                s1_late_reg    [LANES];

    logic [YEAR_W-1:0]   s1_year_next   [LANES];
    logic [SERIAL_W-1:0] s1_y365_next   [LANES];
    logic [12:0]         s1_q4_next     [LANES];
    logic [25:0]         s1_p100_next   [LANES];
    logic [23:0]         s1_p400_next   [LANES];
    logic [26:0]         s1_p25_next    [LANES];
    logic [DOY_W-1:0]    s1_doy_next    [LANES];
    logic                s1_late_next   [LANES];

    logic [YEAR_W:0]     y_p3   [LANES];
    logic [YEAR_W:0]     y_p99  [LANES];
    logic [YEAR_W:0]     y_p399 [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            y_p3[i]   = {1'b0, in_year[i]} + 15'd3;
            y_p99[i]  = {1'b0, in_year[i]} + 15'd99;
            y_p399[i] = {1'b0, in_year[i]} + 15'd399;

            s1_year_next[i] = in_year[i];
            s1_y365_next[i] = SERIAL_W'(in_year[i]) * SERIAL_W'(DAYS_PER_YEAR);
            s1_q4_next[i]   = y_p3[i][YEAR_W:2];
            // (y + 99) / 100 = ((y + 99) >> 2) / 25
            s1_p100_next[i] = 26'(y_p99[i][YEAR_W:2]) * 26'(DIV25_MUL);
            // (y + 399) / 400 = ((y + 399) >> 4) / 25
            s1_p400_next[i] = 24'(y_p399[i][YEAR_W:4]) * 24'(DIV25_MUL);
            // y / 25 for the century test
            s1_p25_next[i]  = 27'(in_year[i]) * 27'(DIV25_MUL);
            s1_doy_next[i]  = months_before(in_month[i]) + DOY_W'(in_day[i]);
            s1_late_next[i] = (in_month[i] >= MONTH_MARCH);
        end
    end

    // stage 2: quotients, leap year and days before the year
    logic [SERIAL_W-1:0] s2_dby_reg  [LANES];
    logic [DOY_W-1:0]    s2_doy_reg  [LANES];
    logic [SERIAL_W-1:0] s2_dby_next [LANES];
    logic [DOY_W-1:0]    s2_doy_next [LANES];

    logic [7:0]          q100  [LANES];
    logic [6:0]          q400  [LANES];
    logic [9:0]          q25   [LANES];
    logic [YEAR_W:0]     q25x  [LANES];
    logic                by25  [LANES];
    logic                leap  [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            q100[i] = s1_p100_reg[i][DIV25_SHIFT+7:DIV25_SHIFT];
            q400[i] = s1_p400_reg[i][DIV25_SHIFT+6:DIV25_SHIFT];
            q25[i]  = s1_p25_reg[i][DIV25_SHIFT+9:DIV25_SHIFT];
            q25x[i] = 15'(q25[i]) * 15'(DIV25_BASE);
            by25[i] = (q25x[i] == {1'b0, s1_year_reg[i]});
            // divisible by 4, and either not by 100 or also by 400
            leap[i] = (s1_year_reg[i][1:0] == 2'b00)
                      && (!by25[i] || (s1_year_reg[i][3:0] == 4'b0000));
            s2_dby_next[i] = s1_y365_reg[i] + SERIAL_W'(s1_q4_reg[i])
                             - SERIAL_W'(q100[i]) + SERIAL_W'(q400[i]);
            s2_doy_next[i] = s1_doy_reg[i] + DOY_W'(s1_late_reg[i] && leap[i]);
        end
    end

    // stage 3: serial day numbers
    logic [SERIAL_W-1:0] s3_serial_reg  [LANES];
    logic [SERIAL_W-1:0] s3_serial_next [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            s3_serial_next[i] = s2_dby_reg[i] + SERIAL_W'(s2_doy_reg[i]);
        end
    end

    // stage 4: signed difference
    logic [SERIAL_W:0] s4_diff_reg;
    logic [SERIAL_W:0] s4_diff_next;

    assign s4_diff_next = {1'b0, s3_serial_reg[0]} - {1'b0, s3_serial_reg[1]};

    // stage 5: magnitude and saturation into the output register
    logic [DIST_W-1:0]   s5_dist_reg;
    logic [DIST_W-1:0]   s5_dist_next;
    logic [SERIAL_W:0]   diff_neg;
    logic [SERIAL_W-1:0] mag;

    always_comb
    begin
        diff_neg = -s4_diff_reg;
        mag      = s4_diff_reg[SERIAL_W] ? diff_neg[SERIAL_W-1:0]
                                         : s4_diff_reg[SERIAL_W-1:0];
        if (mag > SERIAL_W'(DIST_MAX))
        begin
            s5_dist_next = DIST_MAX;
        end
        else
        begin
            s5_dist_next = mag[DIST_W-1:0];
        end
    end

    // valid bits move with the data
    always_comb
    begin
        v1_next = rdy1 ? dates.valid : v1_reg;
        v2_next = rdy2 ? v1_reg      : v2_reg;
        v3_next = rdy3 ? v2_reg      : v3_reg;
        v4_next = rdy4 ? v3_reg      : v4_reg;
        v5_next = rdy5 ? v4_reg      : v5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    // payload registers, loaded when a stage takes a new request
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (rdy1 && dates.valid)
            begin
                s1_year_reg[i] <= s1_year_next[i];
                s1_y365_reg[i] <= s1_y365_next[i];
                s1_q4_reg[i]   <= s1_q4_next[i];
                s1_p100_reg[i] <= s1_p100_next[i];
                s1_p400_reg[i] <= s1_p400_next[i];
                s1_p25_reg[i]  <= s1_p25_next[i];
                s1_doy_reg[i]  <= s1_doy_next[i];
                s1_late_reg[i] <= s1_late_next[i];
            end
            if (rdy2 && v1_reg)
            begin
                s2_dby_reg[i] <= s2_dby_next[i];
                s2_doy_reg[i] <= s2_doy_next[i];
            end
            if (rdy3 && v2_reg)
            begin
                s3_serial_reg[i] <= s3_serial_next[i];
            end
        end
        if (rdy4 && v3_reg)
        begin
            s4_diff_reg <= s4_diff_next;
        end
        if (rdy5 && v4_reg)
        begin
            s5_dist_reg <= s5_dist_next;
        end
    end

    // result channel
    assign result.valid        = v5_reg;
    assign result.day_distance = s5_dist_reg;

    // checks
    logic [4:0] occ_vec;
    logic       in_acc;
    logic       out_acc;

    assign occ_vec = {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg};
    assign in_acc  = dates.valid && dates.ready;
    assign out_acc = result.valid && result.ready;

    // occupancy follows accepted requests minus delivered results
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(occ_vec) == $past($countones(occ_vec))
                                + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline occupancy does not match handshakes");

    // the request side only stalls when every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !dates.ready |-> (occ_vec == 5'b11111))
        else $error("request stalled with a free pipeline stage");

    // a stalled result stage keeps its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !result.ready) |=> v5_reg)
        else $error("result dropped while stalled");

endmodule
